/* rtl/bvc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvc_pkg: shared types and constants for the box view cone test
// Widths of the corner offset, dot product and squared terms, the queue item
// and the per-stage control word.
// ----------------------------------------------------------------------------
package bvc_pkg;

    localparam int COORD_BITS = 24;
    localparam int HALF_BITS  = COORD_BITS - 1;
    localparam int DIR_BITS   = 16;

    // corner offset v = center +/- half - agent
    localparam int V_BITS   = COORD_BITS + 2;
    localparam int VM_BITS  = V_BITS - 1;
    // d * v and the sum of three of them
    localparam int P_BITS   = DIR_BITS + V_BITS;
    localparam int DOT_BITS = P_BITS + 2;
    localparam int DM_BITS  = DOT_BITS - 1;
    // |c| * |v|
    localparam int T_BITS   = DIR_BITS + VM_BITS;
    localparam int TL_BITS  = (T_BITS + 1) / 2;
    localparam int TH_BITS  = T_BITS - TL_BITS;
    localparam int SQ_BITS  = 2 * T_BITS;
    // |dot| split
    localparam int DL_BITS  = (DM_BITS + 1) / 2;
    localparam int DH_BITS  = DM_BITS - DL_BITS;
    localparam int CMP_BITS = 2 * DM_BITS;

    localparam int CORNERS  = 8;
    localparam int K_BITS   = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    // configuration register indexes
    localparam logic REG_SIGHT_ENABLED = 1'b0;
    localparam logic REG_COS_HALF_FOV  = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] agent_x;
        logic signed [COORD_BITS-1:0] agent_y;
        logic signed [COORD_BITS-1:0] agent_z;
        logic signed [DIR_BITS-1:0]   dir_x;
        logic signed [DIR_BITS-1:0]   dir_y;
        logic signed [DIR_BITS-1:0]   dir_z;
        logic signed [COORD_BITS-1:0] ctr_x;
        logic signed [COORD_BITS-1:0] ctr_y;
        logic signed [COORD_BITS-1:0] ctr_z;
        logic [HALF_BITS-1:0]         half_x;
        logic [HALF_BITS-1:0]         half_y;
        logic [HALF_BITS-1:0]         half_z;
    } t_item;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic zero;
    } t_ctl;

endpackage

/* rtl/bvc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvc_front: query intake queue
// Takes each query transfer into a short queue and presents the oldest one
// to the corner engine, which releases it after its last corner.
// ----------------------------------------------------------------------------
module bvc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bvc_pkg::t_item i_item,
    input  logic           i_pop,
    output bvc_pkg::t_item o_head,
    output logic           o_head_valid,
    output logic           o_full
);
    import bvc_pkg::*;

    t_item                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count,  n_count;

    assign o_full       = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // advance pointers and occupancy
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QCNT_BITS'(i_push) - QCNT_BITS'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // store the query payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |=> r_count == QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue occupancy changed while full and idle");

endmodule

/* rtl/bvc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvc_back: corner engine
// Steps through the eight corners of the head query, one a cycle, through a
// shared dot and squared-norm pipeline, and ORs the corner verdicts.
// ----------------------------------------------------------------------------
module bvc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bvc_pkg::t_item                      i_head,
    input  logic                                i_head_valid,
    input  logic                                i_sight,
    input  logic signed [bvc_pkg::DIR_BITS-1:0] i_cos,
    output logic                                o_pop,
    output logic                                o_strobe,
    output logic                                o_visible
);
    import bvc_pkg::*;

    logic [K_BITS-1:0] r_k;
    logic              k_last;

    // stage 0: corner offsets
    t_ctl                     r_s0;
    logic signed [V_BITS-1:0] r_v0, r_v1, r_v2;
    logic signed [DIR_BITS-1:0] r_d0, r_d1, r_d2;
    logic signed [V_BITS-1:0] n_v0, n_v1, n_v2;

    // stage 1: products
    t_ctl                     r_s1;
    logic signed [P_BITS-1:0] r_p0, r_p1, r_p2;
    logic [T_BITS-1:0]        r_t0, r_t1, r_t2;
    logic [DIR_BITS-1:0]      cm;
    logic [VM_BITS-1:0]       vm0, vm1, vm2;

    // stage 2: dot sum, partial squares of t
    t_ctl                       r_s2;
    logic signed [DOT_BITS-1:0] r_dot;
    logic [2*TH_BITS-1:0]       r_hh0, r_hh1, r_hh2;
    logic [TH_BITS+TL_BITS-1:0] r_hl0, r_hl1, r_hl2;
    logic [2*TL_BITS-1:0]       r_ll0, r_ll1, r_ll2;

    // stage 3: squares of t, partial square of |dot|
    t_ctl                       r_s3;
    logic                       r_neg3;
    logic [SQ_BITS-1:0]         r_sq0, r_sq1, r_sq2;
    logic [2*DH_BITS-1:0]       r_dhh;
    logic [DH_BITS+DL_BITS-1:0] r_dhl;
    logic [2*DL_BITS-1:0]       r_dll;
    logic [DM_BITS-1:0]         dm;

    // stage 4: both sides of the comparison
    t_ctl                  r_s4;
    logic                  r_neg4;
    logic [CMP_BITS-1:0]   r_lhs, r_rhs;

    // output
    logic r_acc, n_acc;
    logic r_strobe, r_visible;
    logic corner_vis, c_le0, c_lt0;

    assign k_last = (r_k == K_BITS'(CORNERS - 1));
    assign o_pop  = i_head_valid && k_last;

    // advance the corner index while a query is present
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_head_valid) begin
            r_k <= r_k + 1'b1;
        end
    end

    // form corner k: bit 2 picks +x, bit 1 +y, bit 0 +z
    always_comb begin
        n_v0 = V_BITS'(i_head.ctr_x) - V_BITS'(i_head.agent_x)
             + (r_k[2] ? $signed(V_BITS'(i_head.half_x)) : -$signed(V_BITS'(i_head.half_x)));
        n_v1 = V_BITS'(i_head.ctr_y) - V_BITS'(i_head.agent_y)
             + (r_k[1] ? $signed(V_BITS'(i_head.half_y)) : -$signed(V_BITS'(i_head.half_y)));
        n_v2 = V_BITS'(i_head.ctr_z) - V_BITS'(i_head.agent_z)
             + (r_k[0] ? $signed(V_BITS'(i_head.half_z)) : -$signed(V_BITS'(i_head.half_z)));
    end

    // magnitudes for the norm side and for the dot product
    always_comb begin
        cm  = i_cos[DIR_BITS-1] ? DIR_BITS'(-i_cos) : DIR_BITS'(i_cos);
        vm0 = r_v0[V_BITS-1] ? VM_BITS'(-r_v0) : VM_BITS'(r_v0);
        vm1 = r_v1[V_BITS-1] ? VM_BITS'(-r_v1) : VM_BITS'(r_v1);
        vm2 = r_v2[V_BITS-1] ? VM_BITS'(-r_v2) : VM_BITS'(r_v2);
        dm  = r_dot[DOT_BITS-1] ? DM_BITS'(-r_dot) : DM_BITS'(r_dot);
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
        end else begin
            r_s0.valid <= i_head_valid;
            r_s0.first <= (r_k == '0);
            r_s0.last  <= k_last;
            r_s0.zero  <= 1'b0;
            r_s1.valid <= r_s0.valid;
            r_s1.first <= r_s0.first;
            r_s1.last  <= r_s0.last;
            r_s1.zero  <= (r_v0 == '0) && (r_v1 == '0) && (r_v2 == '0);
            r_s2       <= r_s1;
            r_s3       <= r_s2;
            r_s4       <= r_s3;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_v0 <= n_v0;
        r_v1 <= n_v1;
        r_v2 <= n_v2;
        r_d0 <= i_head.dir_x;
        r_d1 <= i_head.dir_y;
        r_d2 <= i_head.dir_z;

        r_p0 <= r_d0 * r_v0;
        r_p1 <= r_d1 * r_v1;
        r_p2 <= r_d2 * r_v2;
        r_t0 <= cm * vm0;
        r_t1 <= cm * vm1;
        r_t2 <= cm * vm2;

        r_dot <= DOT_BITS'(r_p0) + DOT_BITS'(r_p1) + DOT_BITS'(r_p2);
        r_hh0 <= r_t0[T_BITS-1:TL_BITS] * r_t0[T_BITS-1:TL_BITS];
        r_hl0 <= r_t0[T_BITS-1:TL_BITS] * r_t0[TL_BITS-1:0];
        r_ll0 <= r_t0[TL_BITS-1:0] * r_t0[TL_BITS-1:0];
        r_hh1 <= r_t1[T_BITS-1:TL_BITS] * r_t1[T_BITS-1:TL_BITS];
        r_hl1 <= r_t1[T_BITS-1:TL_BITS] * r_t1[TL_BITS-1:0];
        r_ll1 <= r_t1[TL_BITS-1:0] * r_t1[TL_BITS-1:0];
        r_hh2 <= r_t2[T_BITS-1:TL_BITS] * r_t2[T_BITS-1:TL_BITS];
        r_hl2 <= r_t2[T_BITS-1:TL_BITS] * r_t2[TL_BITS-1:0];
        r_ll2 <= r_t2[TL_BITS-1:0] * r_t2[TL_BITS-1:0];

        r_neg3 <= r_dot[DOT_BITS-1];
        r_sq0  <= (SQ_BITS'(r_hh0) << (2 * TL_BITS)) + (SQ_BITS'(r_hl0) << (TL_BITS + 1))
                + SQ_BITS'(r_ll0);
        r_sq1  <= (SQ_BITS'(r_hh1) << (2 * TL_BITS)) + (SQ_BITS'(r_hl1) << (TL_BITS + 1))
                + SQ_BITS'(r_ll1);
        r_sq2  <= (SQ_BITS'(r_hh2) << (2 * TL_BITS)) + (SQ_BITS'(r_hl2) << (TL_BITS + 1))
                + SQ_BITS'(r_ll2);
        r_dhh  <= dm[DM_BITS-1:DL_BITS] * dm[DM_BITS-1:DL_BITS];
        r_dhl  <= dm[DM_BITS-1:DL_BITS] * dm[DL_BITS-1:0];
        r_dll  <= dm[DL_BITS-1:0] * dm[DL_BITS-1:0];

        r_neg4 <= r_neg3;
        r_rhs  <= CMP_BITS'(r_sq0) + CMP_BITS'(r_sq1) + CMP_BITS'(r_sq2);
        r_lhs  <= (CMP_BITS'(r_dhh) << (2 * DL_BITS)) + (CMP_BITS'(r_dhl) << (DL_BITS + 1))
                + CMP_BITS'(r_dll);
    end

    // decide the corner by a zero offset, by signs, then by the squared comparison
    always_comb begin
        c_lt0      = i_cos[DIR_BITS-1];
        c_le0      = c_lt0 || (i_cos == '0);
        corner_vis = r_s4.zero
                  || (!r_neg4 && c_le0)
                  || (!r_neg4 && !c_le0 && (r_lhs >= r_rhs))
                  || (r_neg4 && c_lt0 && (r_lhs <= r_rhs));
        n_acc      = (r_s4.first ? 1'b0 : r_acc) | corner_vis;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_s4.valid && r_s4.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s4.valid) begin
            r_acc <= n_acc;
        end
        r_visible <= i_sight && n_acc;
    end

    assign o_strobe  = r_strobe;
    assign o_visible = r_visible;

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4.valid && r_s4.last |=> o_strobe)
        else $error("last corner did not produce a result");
    a_first_k0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid && (r_k == '0) |=> r_s0.valid && r_s0.first)
        else $error("first corner not marked");
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_s0.valid && r_s0.last)
        else $error("query released before its last corner");

endmodule

/* rtl/box_view_cone_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_view_cone_test: view cone test against the corners of a box
// Each query runs one corner a cycle through the shared dot and
// squared-norm pipeline; a 2-entry queue takes queries ahead.
// Reset clears the registers (sight off, cosine zero) and the queue; the
// result receiver cannot stall, each result strobe lasts one cycle.
// ----------------------------------------------------------------------------
module box_view_cone_test (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [bvc_pkg::COORD_BITS-1:0] i_agent_x,
    input  logic signed [bvc_pkg::COORD_BITS-1:0] i_agent_y,
    input  logic signed [bvc_pkg::COORD_BITS-1:0] i_agent_z,
    input  logic signed [bvc_pkg::DIR_BITS-1:0]   i_dir_x,
    input  logic signed [bvc_pkg::DIR_BITS-1:0]   i_dir_y,
    input  logic signed [bvc_pkg::DIR_BITS-1:0]   i_dir_z,
    input  logic signed [bvc_pkg::COORD_BITS-1:0] i_box_center_x,
    input  logic signed [bvc_pkg::COORD_BITS-1:0] i_box_center_y,
    input  logic signed [bvc_pkg::COORD_BITS-1:0] i_box_center_z,
    input  logic [bvc_pkg::HALF_BITS-1:0]         i_box_half_x,
    input  logic [bvc_pkg::HALF_BITS-1:0]         i_box_half_y,
    input  logic [bvc_pkg::HALF_BITS-1:0]         i_box_half_z,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [bvc_pkg::DIR_BITS-1:0]          i_cfg_data,
    output logic                                  o_strobe,
    output logic                                  o_visible
);
    import bvc_pkg::*;

    logic                       r_sight;
    logic signed [DIR_BITS-1:0] r_cos;
    t_item                      item, head;
    logic                       head_valid, pop, full;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sight <= 1'b0;
            r_cos   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIGHT_ENABLED: r_sight <= i_cfg_data[0];
                REG_COS_HALF_FOV:  r_cos   <= $signed(i_cfg_data);
                default:           r_sight <= r_sight;
            endcase
        end
    end

    // pack the query
    always_comb begin
        item.agent_x = i_agent_x;
        item.agent_y = i_agent_y;
        item.agent_z = i_agent_z;
        item.dir_x   = i_dir_x;
        item.dir_y   = i_dir_y;
        item.dir_z   = i_dir_z;
        item.ctr_x   = i_box_center_x;
        item.ctr_y   = i_box_center_y;
        item.ctr_z   = i_box_center_z;
        item.half_x  = i_box_half_x;
        item.half_y  = i_box_half_y;
        item.half_z  = i_box_half_z;
    end

    assign busy = full;

    bvc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (start && !full),
        .i_item       (item),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_full       (full)
    );

    bvc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .i_sight      (r_sight),
        .i_cos        (r_cos),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_visible    (o_visible)
    );

endmodule

/* tb/tb_box_view_cone_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_view_cone_test: self-checking bench for the box view cone test
// Sends directed and random queries through the start/busy port and works
// out the visible flag for each one with an exact wide-integer predictor.
// A monitor compares every result strobe, in order, with the queued
// predictions. Between phases the sight enable and cosine registers change
// while the block is idle. The sender idle rate differs between groups of phases.
// ----------------------------------------------------------------------------
module tb_box_view_cone_test;
    import bvc_pkg::*;

    typedef logic signed [127:0] wide_t;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    t_item                         query;
    logic                          i_cfg_we;
    logic                          i_cfg_idx;
    logic [DIR_BITS-1:0]           i_cfg_data;
    logic                          o_strobe;
    logic                          o_visible;

    // register copies seen by the predictor
    logic                          sight_on;
    logic signed [DIR_BITS-1:0]    cone_cos;

    logic                          visible_q[$];
    int                            fail_count;
    int                            sent_count;
    int                            seen_count;
    int                            visible_count;
    int                            idle_pct;

    box_view_cone_test i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_agent_x      (query.agent_x),
        .i_agent_y      (query.agent_y),
        .i_agent_z      (query.agent_z),
        .i_dir_x        (query.dir_x),
        .i_dir_y        (query.dir_y),
        .i_dir_z        (query.dir_z),
        .i_box_center_x (query.ctr_x),
        .i_box_center_y (query.ctr_y),
        .i_box_center_z (query.ctr_z),
        .i_box_half_x   (query.half_x),
        .i_box_half_y   (query.half_y),
        .i_box_half_z   (query.half_z),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_visible      (o_visible)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // one corner against the cone, compared exactly in squared form
    function automatic logic corner_in_cone(wide_t vx, wide_t vy, wide_t vz, t_item it);
        wide_t dot;
        wide_t dot_sq;
        wide_t norm_sq;
        wide_t c;
        c = cone_cos;
        if (vx == 0 && vy == 0 && vz == 0) return 1'b1;
        dot = wide_t'(it.dir_x) * vx + wide_t'(it.dir_y) * vy + wide_t'(it.dir_z) * vz;
        if (dot >= 0 && c <= 0) return 1'b1;
        if (dot < 0 && c >= 0) return 1'b0;
        dot_sq  = dot * dot;
        norm_sq = c * c * (vx * vx + vy * vy + vz * vz);
        if (dot >= 0) return dot_sq >= norm_sq;
        return dot_sq <= norm_sq;
    endfunction

    // any of the eight box corners inside the cone
    function automatic logic box_seen(t_item it);
        wide_t hx, hy, hz, vx, vy, vz;
        logic  seen;
        seen = 1'b0;
        hx = wide_t'({1'b0, it.half_x});
        hy = wide_t'({1'b0, it.half_y});
        hz = wide_t'({1'b0, it.half_z});
        if (sight_on) begin
            for (int k = 0; k < CORNERS; k++) begin
                vx = wide_t'(it.ctr_x) + (k[2] ? hx : -hx) - wide_t'(it.agent_x);
                vy = wide_t'(it.ctr_y) + (k[1] ? hy : -hy) - wide_t'(it.agent_y);
                vz = wide_t'(it.ctr_z) + (k[0] ? hz : -hz) - wide_t'(it.agent_z);
                if (corner_in_cone(vx, vy, vz, it)) seen = 1'b1;
            end
        end
        return seen;
    endfunction

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            seen_count++;
            if (visible_q.size() == 0) begin
                $error("visible: unexpected result %0b", o_visible);
                fail_count++;
            end else begin
                if (o_visible !== visible_q[0]) begin
                    $error("visible: expected %0b, got %0b", visible_q[0], o_visible);
                    fail_count++;
                end
                visible_count += visible_q[0];
                void'(visible_q.pop_front());
            end
        end
    end

    // send one query; start stays high after the transfer
    task automatic send_query(input t_item it);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        query <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        visible_q.push_back(box_seen(it));
        sent_count++;
    endtask

    // drop start and wait for all results plus the pipeline depth
    task automatic drain;
        start <= 1'b0;
        while (visible_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIR_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_SIGHT_ENABLED) sight_on = data[0];
        else cone_cos = data;
    endtask

    task automatic set_config(input logic en, input logic [DIR_BITS-1:0] c);
        drain();
        write_reg(REG_SIGHT_ENABLED, {15'd0, en});
        write_reg(REG_COS_HALF_FOV, c);
    endtask

    function automatic t_item make_item(
        input int ax, input int ay, input int az,
        input int dx, input int dy, input int dz,
        input int cx, input int cy, input int cz,
        input int hx, input int hy, input int hz);
        t_item it;
        it.agent_x = COORD_BITS'(ax); it.agent_y = COORD_BITS'(ay);
        it.agent_z = COORD_BITS'(az);
        it.dir_x = DIR_BITS'(dx); it.dir_y = DIR_BITS'(dy); it.dir_z = DIR_BITS'(dz);
        it.ctr_x = COORD_BITS'(cx); it.ctr_y = COORD_BITS'(cy); it.ctr_z = COORD_BITS'(cz);
        it.half_x = HALF_BITS'(hx); it.half_y = HALF_BITS'(hy); it.half_z = HALF_BITS'(hz);
        return it;
    endfunction

    function automatic int small_off(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // random query: mostly local scenes, some full-range noise, corners on the agent and degenerate directions
    function automatic t_item random_item;
        t_item it;
        int    mode;
        mode = $urandom_range(0, 9);
        it = $bits(t_item)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom});
        if (mode >= 2 && mode <= 7) begin
            it.agent_x = COORD_BITS'(small_off(1 << 20));
            it.agent_y = COORD_BITS'(small_off(1 << 20));
            it.agent_z = COORD_BITS'(small_off(1 << 20));
            it.ctr_x = COORD_BITS'(it.agent_x + small_off(1 << 12));
            it.ctr_y = COORD_BITS'(it.agent_y + small_off(1 << 12));
            it.ctr_z = COORD_BITS'(it.agent_z + small_off(1 << 12));
            it.half_x = HALF_BITS'($urandom_range(0, 1 << 11));
            it.half_y = HALF_BITS'($urandom_range(0, 1 << 11));
            it.half_z = HALF_BITS'($urandom_range(0, 1 << 11));
            if (mode == 7) begin
                it.dir_x = DIR_BITS'(small_off(64));
                it.dir_y = DIR_BITS'(small_off(64));
                it.dir_z = DIR_BITS'(32767);
            end
        end else if (mode == 8) begin
            // a corner sits exactly on the agent
            it.agent_x = COORD_BITS'(small_off(1 << 20));
            it.agent_y = COORD_BITS'(small_off(1 << 20));
            it.agent_z = COORD_BITS'(small_off(1 << 20));
            it.half_x = HALF_BITS'($urandom_range(0, 1 << 11));
            it.half_y = HALF_BITS'($urandom_range(0, 1 << 11));
            it.half_z = HALF_BITS'($urandom_range(0, 1 << 11));
            it.ctr_x = $urandom_range(0, 1) ? it.agent_x + it.half_x : it.agent_x - it.half_x;
            it.ctr_y = $urandom_range(0, 1) ? it.agent_y + it.half_y : it.agent_y - it.half_y;
            it.ctr_z = $urandom_range(0, 1) ? it.agent_z + it.half_z : it.agent_z - it.half_z;
        end else if (mode == 9) begin
            it.dir_x = '0;
            it.dir_y = '0;
            it.dir_z = $urandom_range(0, 1) ? DIR_BITS'(0) : DIR_BITS'(-32768);
        end
        return it;
    endfunction

    // sight off after reset: every query is invisible
    task automatic test_reset_state;
        idle_pct = 0;
        repeat (4) send_query(random_item());
        send_query(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // extremes, corner on agent, zero and odd directions
    task automatic test_directed;
        set_config(1'b1, 16'h4000);
        send_query(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_item(5, 5, 5, 0, 0, 0, 100, 0, 0, 3, 3, 3));
        send_query(make_item(0, 0, 0, 32767, 0, 0, 100, 0, 0, 1, 1, 1));
        send_query(make_item(0, 0, 0, -32768, 0, 0, 100, 0, 0, 1, 1, 1));
        send_query(make_item(0, 0, 0, 32767, 0, 0, 100, 100, 0, 0, 0, 0));
        send_query(make_item(0, 0, 0, 23170, 23170, 0, 100, 99, 0, 0, 0, 0));
        send_query(make_item(8388607, 8388607, 8388607, -32768, -32768, -32768,
                             -8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
        send_query(make_item(-8388608, -8388608, -8388608, 32767, 32767, 32767,
                             8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
        send_query(make_item(-8388608, 0, 8388607, 32767, -32768, 0,
                             8388607, 0, -8388608, 0, 8388607, 0));
        send_query(make_item(10, 20, 30, 1, 1, 1, 10, 20, 30, 0, 0, 0));
        send_query(make_item(0, 0, 0, 1, 0, 0, -50, 0, 0, 10, 10, 10));
        set_config(1'b1, 16'h8000);
        send_query(make_item(0, 0, 0, 32767, 0, 0, -100, 0, 0, 1, 1, 1));
        send_query(make_item(0, 0, 0, 0, 0, 0, 100, 100, 100, 2, 2, 2));
        send_query(make_item(0, 0, 0, 32767, 0, 0, -100, 3, 0, 0, 0, 0));
        set_config(1'b1, 16'h7FFF);
        send_query(make_item(0, 0, 0, 32767, 0, 0, 100, 0, 0, 0, 0, 0));
        send_query(make_item(0, 0, 0, 32767, 0, 0, 100, 1, 0, 0, 0, 0));
        send_query(make_item(0, 0, 0, 0, 0, 0, 100, 0, 0, 0, 0, 0));
        set_config(1'b1, 16'h0000);
        send_query(make_item(0, 0, 0, 0, 0, 0, 7, 7, 7, 1, 1, 1));
        send_query(make_item(0, 0, 0, 100, 0, 0, -100, 0, 0, 1, 1, 1));
    endtask

    // random phases with varying registers and sender idle rate
    task automatic test_random;
        logic [DIR_BITS-1:0] cos_set[8];
        cos_set = '{16'h8000, 16'h7FFF, 16'h0000, 16'h5A82, 16'hC000,
                    16'h7F00, 16'h0000, 16'h6000};
        for (int p = 0; p < 8; p++) begin
            if (p == 6) set_config(1'b0, DIR_BITS'($urandom));
            else if (p == 3 || p == 7) set_config(1'b1, DIR_BITS'($urandom));
            else set_config(1'b1, cos_set[p]);
            idle_pct = (p < 3) ? 32 : (p < 6) ? 88 : 0;
            repeat (155) send_query(random_item());
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        query      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_SIGHT_ENABLED;
        i_cfg_data = '0;
        sight_on   = 1'b0;
        cone_cos   = '0;
        fail_count = 0;
        sent_count = 0;
        seen_count = 0;
        visible_count = 0;
        idle_pct   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed();
        test_random();
        drain();

        $display("Covered %0d queries (%0d results, %0d visible) over sight on/off,",
                 sent_count, seen_count, visible_count);
        $display("cosine extremes and random values, with and without sender gaps.");
        if (fail_count == 0)
            $display("box_view_cone_test verification clean");
        else
            $display("box_view_cone_test verification failed");
        $finish;
    end

    // hang guard
    initial begin
        #5ms;
        $display("box_view_cone_test verification failed");
        $finish;
    end

endmodule
